@@ rtl/stc_pkg.sv @@
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants of the stick-to-cursor controller
// Stream widths, register indexes, reset values and the axis deadzone helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

    // stream widths (fields packed from bit 0 up, padded to whole bytes)
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 48;

    // field widths
    localparam int unsigned STICK_W = 8;
    localparam int unsigned PTR_W   = 12;
    localparam int unsigned DELTA_W = 9;
    localparam int unsigned DZ_W    = 7;
    localparam int unsigned DIV_W   = 8;

    // configuration port
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 12;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DEADZONE      = 2'd0,
        CFG_SPEED_DIVISOR = 2'd1,
        CFG_SCREEN_WIDTH  = 2'd2,
        CFG_SCREEN_HEIGHT = 2'd3
    } t_cfg_idx;

    // register reset values
    localparam logic [DZ_W-1:0]  RST_DEADZONE      = 7'd30;
    localparam logic [DIV_W-1:0] RST_SPEED_DIVISOR = 8'd8;
    localparam logic [PTR_W-1:0] RST_SCREEN_WIDTH  = 12'd480;
    localparam logic [PTR_W-1:0] RST_SCREEN_HEIGHT = 12'd272;

    // default cursor register width
    localparam int unsigned COORD_WIDTH_DEF = 12;

    // stick center code
    localparam logic [STICK_W-1:0] STICK_CENTER = 8'd127;

    // one quotient bit per cycle
    localparam int unsigned DIV_STEPS = DIV_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_DIV    = 2'd1,
        S_FINISH = 2'd2
    } t_state;

    // magnitude beyond the deadzone and its sign
    typedef struct packed {
        logic             neg;
        logic [DIV_W-1:0] mag;
    } t_axis;

    function automatic t_axis axis_split(input logic [STICK_W-1:0] raw,
                                         input logic [DZ_W-1:0]    dz);
        logic signed [9:0] off;
        logic signed [9:0] pdz;
        logic signed [9:0] m;
        t_axis             res;
        off = $signed({2'b00, raw}) - $signed({2'b00, STICK_CENTER});
        pdz = $signed({3'b000, dz});
        res = '0;
        if (off > pdz) begin
            m       = off - pdz;
            res.mag = m[DIV_W-1:0];
        end else if (off < -pdz) begin
            m       = -off - pdz;
            res.mag = m[DIV_W-1:0];
            res.neg = 1'b1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/stick_to_cursor_controller.sv @@
// ----------------------------------------------------------------------------
// stick_to_cursor_controller: analog stick frame to pointer events
// Removes the deadzone, divides each axis with a shared bit-serial divider,
// then updates the cursor, scroll and button events of one frame.
// ----------------------------------------------------------------------------
// Sequence: an accepted item is captured, the shared restoring divider forms the
//   8-bit x quotient and then the 8-bit y quotient, and a finish step loads the result.
// A new item is accepted only in the idle state, after the finish step; the finish
//   step waits while an earlier result is still held for i_m_tready.
// Reset (i_rst_n low, synchronous): cursor at 0,0, pointer mode, registers at
//   deadzone 30, divisor 8, width 480, height 272, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module stick_to_cursor_controller #(
    parameter int unsigned COORD_WIDTH = stc_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [stc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [stc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // input items
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // stick_x[7:0], stick_y[15:8], scroll_held[16], toggle_released[17],
    // press_edge[18], release_edge[19], zero[23:20]
    input  wire logic [stc_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // result items
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // keyboard_mode[0], pointer_x[12:1], pointer_y[24:13], moved[25],
    // scroll_valid[26], scroll_dx[35:27], scroll_dy[44:36], button_up[45],
    // button_down[46], zero[47]
    output logic [stc_pkg::OUT_DATA_W-1:0]       o_m_tdata
);
    import stc_pkg::*;

    // width that holds cursor + delta and the limits with sign
    localparam int unsigned SW = ((COORD_WIDTH > PTR_W) ? COORD_WIDTH : PTR_W) + 2;
    localparam logic signed [SW-1:0] COORD_MAX = SW'((1 << COORD_WIDTH) - 1);

    // configuration registers
    logic [DZ_W-1:0]  r_deadzone;
    logic [DIV_W-1:0] r_divisor;
    logic [PTR_W-1:0] r_width;
    logic [PTR_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= RST_DEADZONE;
            r_divisor  <= RST_SPEED_DIVISOR;
            r_width    <= RST_SCREEN_WIDTH;
            r_height   <= RST_SCREEN_HEIGHT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_DEADZONE:      r_deadzone <= i_cfg_wdata[DZ_W-1:0];
                CFG_SPEED_DIVISOR: r_divisor  <= i_cfg_wdata[DIV_W-1:0];
                CFG_SCREEN_WIDTH:  r_width    <= i_cfg_wdata[PTR_W-1:0];
                CFG_SCREEN_HEIGHT: r_height   <= i_cfg_wdata[PTR_W-1:0];
                default: ;
            endcase
        end
    end

    // control
    t_state r_state;
    t_state n_state;
    logic   w_s_acc;
    logic   w_last_bit;
    logic   w_load_out;
    logic   r_axis;
    logic [CNT_W-1:0] r_cnt;
    logic   r_out_valid;

    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_last_bit = (r_cnt == CNT_W'(DIV_STEPS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_s_tvalid) n_state = S_DIV;
            S_DIV:    if (w_last_bit && r_axis) n_state = S_FINISH;
            S_FINISH: if (!r_out_valid || i_m_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE:   o_s_tready = 1'b1;
            S_DIV:    ;
            S_FINISH: w_load_out = !r_out_valid || i_m_tready;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // captured item
    t_axis w_ax;
    t_axis w_ay;
    logic  r_neg_x;
    logic  r_neg_y;
    logic [DIV_W-1:0] r_mag_y;
    logic  r_scroll;
    logic  r_toggle;
    logic  r_press;
    logic  r_release;

    assign w_ax = axis_split(i_s_tdata[7:0], r_deadzone);
    assign w_ay = axis_split(i_s_tdata[15:8], r_deadzone);

    // bit-serial restoring divider, shared by both axes
    logic [DIV_W-1:0] w_div_eff;
    logic [DIV_W:0]   w_shift;
    logic             w_ge;
    logic [DIV_W:0]   w_diff;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] w_quo_next;
    logic [DIV_W-1:0] r_qx;
    logic [DIV_W-1:0] r_qy;

    assign w_div_eff  = (r_divisor == '0) ? DIV_W'(1) : r_divisor;
    assign w_shift    = {r_rem, r_quo[DIV_W-1]};
    assign w_ge       = (w_shift >= {1'b0, w_div_eff});
    assign w_diff     = w_shift - {1'b0, w_div_eff};
    assign w_quo_next = {r_quo[DIV_W-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_axis <= 1'b0;
        end else if (w_s_acc) begin
            r_cnt  <= '0;
            r_axis <= 1'b0;
        end else if (r_state == S_DIV) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (w_last_bit) begin
                r_axis <= 1'b1;
            end
        end
    end

    // divider datapath and item capture
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_neg_x   <= w_ax.neg;
            r_neg_y   <= w_ay.neg;
            r_mag_y   <= w_ay.mag;
            r_quo     <= w_ax.mag;
            r_rem     <= '0;
            r_scroll  <= i_s_tdata[16];
            r_toggle  <= i_s_tdata[17];
            r_press   <= i_s_tdata[18];
            r_release <= i_s_tdata[19];
        end else if (r_state == S_DIV) begin
            if (w_last_bit && !r_axis) begin
                r_qx  <= w_quo_next;
                r_quo <= r_mag_y;
                r_rem <= '0;
            end else begin
                r_quo <= w_quo_next;
                r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
                if (w_last_bit) begin
                    r_qy <= w_quo_next;
                end
            end
        end
    end

    // finish: signed deltas, clamp, events
    logic [COORD_WIDTH-1:0] r_cur_x;
    logic [COORD_WIDTH-1:0] r_cur_y;
    logic                   r_kb;
    logic signed [DELTA_W-1:0] w_dx;
    logic signed [DELTA_W-1:0] w_dy;
    logic [SW-1:0]          w_cx_ext;
    logic [SW-1:0]          w_cy_ext;
    logic signed [SW-1:0]   w_sum_x;
    logic signed [SW-1:0]   w_sum_y;
    logic signed [SW-1:0]   w_hi_x;
    logic signed [SW-1:0]   w_hi_y;
    logic signed [SW-1:0]   w_nx;
    logic signed [SW-1:0]   w_ny;
    logic                   w_kb_next;
    logic                   w_do_move;
    logic                   w_moved;

    assign w_dx = r_neg_x ? -$signed({1'b0, r_qx}) : $signed({1'b0, r_qx});
    assign w_dy = r_neg_y ? -$signed({1'b0, r_qy}) : $signed({1'b0, r_qy});

    assign w_cx_ext = {{(SW - COORD_WIDTH){1'b0}}, r_cur_x};
    assign w_cy_ext = {{(SW - COORD_WIDTH){1'b0}}, r_cur_y};
    assign w_sum_x  = $signed(w_cx_ext) + SW'(w_dx);
    assign w_sum_y  = $signed(w_cy_ext) + SW'(w_dy);

    // limit is the smaller of the screen size and the register range
    assign w_hi_x = ($signed(SW'(r_width)) > COORD_MAX) ? COORD_MAX : $signed(SW'(r_width));
    assign w_hi_y = ($signed(SW'(r_height)) > COORD_MAX) ? COORD_MAX
                                                         : $signed(SW'(r_height));

    always_comb begin
        if (w_sum_x < 0) begin
            w_nx = '0;
        end else if (w_sum_x > w_hi_x) begin
            w_nx = w_hi_x;
        end else begin
            w_nx = w_sum_x;
        end
        if (w_sum_y < 0) begin
            w_ny = '0;
        end else if (w_sum_y > w_hi_y) begin
            w_ny = w_hi_y;
        end else begin
            w_ny = w_sum_y;
        end
    end

    assign w_kb_next = r_kb ^ r_toggle;
    assign w_do_move = !w_kb_next && !r_scroll;
    assign w_moved   = w_do_move && ((w_nx[COORD_WIDTH-1:0] != r_cur_x) ||
                                     (w_ny[COORD_WIDTH-1:0] != r_cur_y));

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_kb    <= 1'b0;
        end else if (w_load_out) begin
            r_kb <= w_kb_next;
            if (w_do_move) begin
                r_cur_x <= w_nx[COORD_WIDTH-1:0];
                r_cur_y <= w_ny[COORD_WIDTH-1:0];
            end
        end
    end

    // output register
    logic [SW-1:0]          w_px_ext;
    logic [SW-1:0]          w_py_ext;
    logic                   w_sv;
    logic                   w_ev;
    logic [OUT_DATA_W-1:0]  r_out_data;

    assign w_px_ext = w_do_move ? w_nx : w_cx_ext;
    assign w_py_ext = w_do_move ? w_ny : w_cy_ext;
    assign w_sv     = !w_kb_next && r_scroll;
    assign w_ev     = !w_kb_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= {1'b0,
                           w_ev & r_press,
                           w_ev & r_release,
                           w_sv ? w_dy : DELTA_W'(0),
                           w_sv ? w_dx : DELTA_W'(0),
                           w_sv,
                           w_moved,
                           w_py_ext[PTR_W-1:0],
                           w_px_ext[PTR_W-1:0],
                           w_kb_next};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // checks
    a_acc_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> (r_state == S_DIV))
        else $error("accepted item did not start the divider");

    a_rise_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FINISH))
        else $error("result appeared without a finish step");

    a_kb_no_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |->
            (!o_m_tdata[25] && !o_m_tdata[26] && !o_m_tdata[45] && !o_m_tdata[46]))
        else $error("pointer event in keyboard mode");

    a_scroll_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[26]) |-> (o_m_tdata[44:27] == '0))
        else $error("scroll amount without scroll event");

endmodule

`default_nettype wire

@@ verif/stick_to_cursor_controller_tb.sv @@
// ----------------------------------------------------------------------------
// stick_to_cursor_controller_tb: frame-level regression of the stick cursor
// Drives stick frames on the input stream and predicts each frame report:
// deadzone removal, truncating division, cursor clamp, scroll and keyboard
// mode. A short table of hand-picked frames runs first. Random frames follow
// under several register settings, extremes included. For the earlier frames
// the stream handshakes are throttled at random, and the run checks each
// report field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stick_to_cursor_controller_tb;

    import stc_pkg::*;

    localparam int CLK_HALF_NS   = 6;
    localparam int RST_CYCLES    = 9;
    localparam int SETTLE_CYCLES = 25;      // result latency plus margin
    localparam int FRAMES_PER_CFG = 170;
    localparam int NUM_CFG       = 8;
    localparam int LIMIT_NS      = 5_000_000;

    // button bits of one frame: {release, press, toggle, scroll}
    localparam int BTN_SCROLL  = 0;
    localparam int BTN_TOGGLE  = 1;
    localparam int BTN_PRESS   = 2;
    localparam int BTN_RELEASE = 3;

    typedef struct packed {
        logic              kbd;
        logic [PTR_W-1:0]  px;
        logic [PTR_W-1:0]  py;
        logic              moved;
        logic              sv;
        logic [DELTA_W-1:0] sdx;
        logic [DELTA_W-1:0] sdy;
        logic              btn_up;
        logic              btn_down;
    } t_frame_report;

    typedef struct packed {
        logic [STICK_W-1:0] sx;
        logic [STICK_W-1:0] sy;
        logic [3:0]         btn;
        logic               typed;
        t_frame_report      want;
    } t_stick_frame_row;

    typedef struct {
        int dz;
        int dv;
        int w;
        int h;
    } t_cursor_cfg;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_DATA_W-1:0]  o_m_tdata;

    stick_to_cursor_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // shadow of the block: registers and cursor state
    logic [DZ_W-1:0]  dz_reg;
    logic [DIV_W-1:0] div_reg;
    logic [PTR_W-1:0] width_reg;
    logic [PTR_W-1:0] height_reg;
    int               cursor_x;
    int               cursor_y;
    bit               kbd_on;

    t_frame_report    pending_reports[$];
    int               mismatches;
    int               frames_sent;
    int               snd_idle_pct;
    int               rcv_idle_pct;

    t_stick_frame_row hand_frames [16];
    t_cursor_cfg      cfg_sets [NUM_CFG] = '{
        '{30,   8,  480,  272},
        '{ 0,   1, 4095, 4095},
        '{127, 128,    1,    1},
        '{ 0,   0,  100,   50},     // zero divisor acts as one
        '{ 5, 255, 4095,    0},
        '{64,   3,    0, 4095},
        '{ 1,   2,  639,  479},
        '{10,  16, 4095, 4095}
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("stick_to_cursor_controller regression: fail");
        $finish;
    end

    // per-axis motion: offset beyond the deadzone, truncated toward zero
    function automatic int stick_step(input logic [STICK_W-1:0] raw);
        int off;
        int dzi;
        int dv;
        off = int'(raw) - int'(STICK_CENTER);
        dzi = int'(dz_reg);
        dv  = (div_reg == '0) ? 1 : int'(div_reg);
        if (off > dzi)
            return (off - dzi) / dv;
        if (off < -dzi)
            return -((-off - dzi) / dv);
        return 0;
    endfunction

    function automatic int clamp_coord(input int v, input logic [PTR_W-1:0] limit);
        if (v < 0)
            return 0;
        if (v > int'(limit))
            return int'(limit);
        return v;
    endfunction

    // advance the shadow state by one frame and return its report
    function automatic t_frame_report predict_frame(input logic [STICK_W-1:0] sx,
                                                    input logic [STICK_W-1:0] sy,
                                                    input logic [3:0]         btn);
        t_frame_report r;
        int dx;
        int dy;
        int nx;
        int ny;
        r = '0;
        if (btn[BTN_TOGGLE])
            kbd_on = !kbd_on;
        if (!kbd_on) begin
            dx = stick_step(sx);
            dy = stick_step(sy);
            if (btn[BTN_SCROLL]) begin
                r.sv  = 1'b1;
                r.sdx = DELTA_W'(dx);
                r.sdy = DELTA_W'(dy);
            end else begin
                nx = clamp_coord(cursor_x + dx, width_reg);
                ny = clamp_coord(cursor_y + dy, height_reg);
                r.moved  = (nx != cursor_x) || (ny != cursor_y);
                cursor_x = nx;
                cursor_y = ny;
            end
            r.btn_up   = btn[BTN_RELEASE];
            r.btn_down = btn[BTN_PRESS];
        end
        r.kbd = kbd_on;
        r.px  = PTR_W'(cursor_x);
        r.py  = PTR_W'(cursor_y);
        return r;
    endfunction

    // random stick sample, biased toward the rails and the deadzone edges
    function automatic logic [STICK_W-1:0] stick_sample();
        case ($urandom_range(0, 11))
            0: return 8'd0;
            1: return 8'd255;
            2: return STICK_CENTER + 8'(dz_reg);
            3: return STICK_CENTER - 8'(dz_reg);
            4: return STICK_CENTER + 8'(dz_reg) + 8'd1;
            5: return STICK_CENTER - 8'(dz_reg) - 8'd1;
            6: return STICK_CENTER;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // one frame on the input stream; the report is predicted at accept
    task automatic send_frame(input logic [STICK_W-1:0] sx,
                              input logic [STICK_W-1:0] sy,
                              input logic [3:0]         btn,
                              input logic               typed,
                              input t_frame_report      want);
        t_frame_report rep;
        if (frames_sent < 470) begin
            snd_idle_pct = 9;
            rcv_idle_pct = 57;
        end else if (frames_sent < 940) begin
            snd_idle_pct = 57;
            rcv_idle_pct = 9;
        end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
        end
        @(negedge i_clk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0000, btn, sy, sx};
        do @(posedge i_clk); while (!o_s_tready);
        rep = predict_frame(sx, sy, btn);
        pending_reports.push_back(typed ? want : rep);
        frames_sent++;
    endtask

    // stop sending and let every outstanding report come back
    task automatic drain_reports();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= CFG_DATA_W'(val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_DEADZONE:      dz_reg     = DZ_W'(val);
            CFG_SPEED_DIVISOR: div_reg    = DIV_W'(val);
            CFG_SCREEN_WIDTH:  width_reg  = PTR_W'(val);
            CFG_SCREEN_HEIGHT: height_reg = PTR_W'(val);
            default: ;
        endcase
    endtask

    // result side: random back-pressure
    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);

    // result side: compare each report with the oldest prediction
    always @(posedge i_clk) begin
        t_frame_report want;
        t_frame_report got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kbd      = o_m_tdata[0];
            got.px       = o_m_tdata[12:1];
            got.py       = o_m_tdata[24:13];
            got.moved    = o_m_tdata[25];
            got.sv       = o_m_tdata[26];
            got.sdx      = o_m_tdata[35:27];
            got.sdy      = o_m_tdata[44:36];
            got.btn_up   = o_m_tdata[45];
            got.btn_down = o_m_tdata[46];
            if (pending_reports.size() == 0) begin
                mismatches++;
                $display("%0t: report expected none, got %h", $time, o_m_tdata);
            end else begin
                want = pending_reports.pop_front();
                compare_field("keyboard_mode", want.kbd, got.kbd);
                compare_field("pointer_x", want.px, got.px);
                compare_field("pointer_y", want.py, got.py);
                compare_field("moved", want.moved, got.moved);
                compare_field("scroll_valid", want.sv, got.sv);
                compare_field("scroll_dx", int'($signed(want.sdx)), int'($signed(got.sdx)));
                compare_field("scroll_dy", int'($signed(want.sdy)), int'($signed(got.sdy)));
                compare_field("button_up", want.btn_up, got.btn_up);
                compare_field("button_down", want.btn_down, got.btn_down);
            end
        end
    end

    // stimulus
    initial begin
        logic [3:0] btn;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = CFG_DEADZONE;
        i_cfg_wdata  = '0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        mismatches   = 0;
        frames_sent  = 0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        dz_reg       = RST_DEADZONE;
        div_reg      = RST_SPEED_DIVISOR;
        width_reg    = RST_SCREEN_WIDTH;
        height_reg   = RST_SCREEN_HEIGHT;
        cursor_x     = 0;
        cursor_y     = 0;
        kbd_on       = 1'b0;

        // hand-picked frames at reset settings; btn is {release, press, toggle, scroll}
        hand_frames[0]  = '{8'd127, 8'd127, 4'b0000, 1'b1, '0};
        hand_frames[1]  = '{8'd255, 8'd255, 4'b0000, 1'b1,
                            '{px: 12'd12, py: 12'd12, moved: 1'b1, default: '0}};
        hand_frames[2]  = '{8'd0, 8'd0, 4'b0000, 1'b1, '{moved: 1'b1, default: '0}};
        // pinned at the origin
        hand_frames[3]  = '{8'd0, 8'd0, 4'b0000, 1'b1, '0};
        // exactly plus and minus the deadzone
        hand_frames[4]  = '{8'd157, 8'd97, 4'b0000, 1'b1, '0};
        hand_frames[5]  = '{8'd158, 8'd96, 4'b0000, 1'b0, '0};
        hand_frames[6]  = '{8'd255, 8'd0, 4'b0001, 1'b1,
                            '{sv: 1'b1, sdx: 9'd12, sdy: 9'h1F4, default: '0}};
        hand_frames[7]  = '{8'd0, 8'd255, 4'b0001, 1'b0, '0};
        // both cross edges in one frame
        hand_frames[8]  = '{8'd127, 8'd127, 4'b1100, 1'b1,
                            '{btn_up: 1'b1, btn_down: 1'b1, default: '0}};
        hand_frames[9]  = '{8'd127, 8'd127, 4'b0100, 1'b0, '0};
        hand_frames[10] = '{8'd127, 8'd127, 4'b1000, 1'b0, '0};
        // keyboard mode swallows motion, scroll and buttons
        hand_frames[11] = '{8'd255, 8'd255, 4'b1111, 1'b1, '{kbd: 1'b1, default: '0}};
        hand_frames[12] = '{8'd255, 8'd0, 4'b0101, 1'b1, '{kbd: 1'b1, default: '0}};
        hand_frames[13] = '{8'd255, 8'd255, 4'b0010, 1'b1,
                            '{px: 12'd12, py: 12'd12, moved: 1'b1, default: '0}};
        hand_frames[14] = '{8'd200, 8'd50, 4'b0000, 1'b0, '0};
        hand_frames[15] = '{8'd255, 8'd255, 4'b0000, 1'b0, '0};

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (hand_frames[k])
            send_frame(hand_frames[k].sx, hand_frames[k].sy, hand_frames[k].btn,
                       hand_frames[k].typed, hand_frames[k].want);

        // random frames under each register setting
        foreach (cfg_sets[p]) begin
            drain_reports();
            write_reg(CFG_DEADZONE, cfg_sets[p].dz);
            write_reg(CFG_SPEED_DIVISOR, cfg_sets[p].dv);
            write_reg(CFG_SCREEN_WIDTH, cfg_sets[p].w);
            write_reg(CFG_SCREEN_HEIGHT, cfg_sets[p].h);
            repeat (FRAMES_PER_CFG) begin
                btn = '0;
                btn[BTN_SCROLL]  = ($urandom_range(0, 3) == 0);
                // leave keyboard mode quickly so most frames act on the pointer
                btn[BTN_TOGGLE]  = kbd_on ? ($urandom_range(0, 2) == 0)
                                          : ($urandom_range(0, 24) == 0);
                btn[BTN_PRESS]   = ($urandom_range(0, 4) == 0);
                btn[BTN_RELEASE] = ($urandom_range(0, 4) == 0);
                send_frame(stick_sample(), stick_sample(), btn, 1'b0, '0);
            end
        end

        drain_reports();
        if (mismatches == 0)
            $display("stick_to_cursor_controller regression: pass");
        else
            $display("stick_to_cursor_controller regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/stc_pkg.sv
rtl/stick_to_cursor_controller.sv
verif/stick_to_cursor_controller_tb.sv
